// ===== rtl/rha_pkg.sv =====
package rha_pkg;

    localparam int CH_W      = 3;
    localparam int RATE_W    = 32;
    localparam int AVG_W     = 43;
    localparam int PEAK_W    = 35;
    localparam int WIN_W     = 8;
    localparam int UNIT_W    = 20;
    localparam int FRAC_BITS = 8;
    localparam int BYTE_SHIFT = 3;

    localparam int DEF_HISTORY  = 128;
    localparam int DEF_CHANNELS = 8;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNIT   = 2'd1;

    localparam logic [WIN_W-1:0]  WIN_RESET  = 8'd10;
    localparam logic [UNIT_W-1:0] UNIT_RESET = 20'd1000;

    typedef struct packed {
        logic [CH_W-1:0]   channel;
        logic [RATE_W-1:0] rx;
        logic [RATE_W-1:0] tx;
        logic              in_range;
    } rha_item_t;

endpackage

// ===== rtl/rha_front.sv =====
module rha_front #(
    parameter int CHANNELS = rha_pkg::DEF_CHANNELS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [rha_pkg::CH_W-1:0]   channel,
    input  logic [rha_pkg::RATE_W-1:0] rx_bytes_per_sec,
    input  logic [rha_pkg::RATE_W-1:0] tx_bytes_per_sec,
    output logic                      q_valid,
    input  logic                      q_pop,
    output rha_pkg::rha_item_t        q_item
);
    import rha_pkg::*;

    rha_item_t   entry_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg, count_next;
    logic        push;
    rha_item_t   item_in;

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = entry_reg[rd_ptr_reg];

    // classify: out-of-range channels bypass the history
    always_comb
    begin
        item_in.channel  = channel;
        item_in.rx       = rx_bytes_per_sec;
        item_in.tx       = tx_bytes_per_sec;
        item_in.in_range = (32'(channel) < CHANNELS);
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !(q_pop && q_valid))
            count_next = count_reg + 2'd1;
        else if (!push && q_pop && q_valid)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (q_pop && q_valid)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= item_in;
    end

endmodule

// ===== rtl/rha_divider.sv =====
module rha_divider #(
    parameter int NUM_W = 51,
    parameter int DEN_W = 28
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] num_reg, quo_reg;
    logic [DEN_W-1:0] den_reg, rem_reg;
    logic [DEN_W:0]   trial, diff;
    logic             ge;

    // restoring division, one quotient bit per cycle
    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign ge    = (trial >= {1'b0, den_reg});
    assign diff  = trial - {1'b0, den_reg};
    assign done  = done_reg;
    assign quo   = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            rem_reg <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
        end
    end

endmodule

// ===== rtl/rha_back.sv =====
module rha_back #(
    parameter int HISTORY  = rha_pkg::DEF_HISTORY,
    parameter int CHANNELS = rha_pkg::DEF_CHANNELS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    output logic                       q_pop,
    input  rha_pkg::rha_item_t         q_item,
    input  logic [rha_pkg::WIN_W-1:0]  win_cfg,
    input  logic [rha_pkg::UNIT_W-1:0] unit_cfg,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [rha_pkg::CH_W-1:0]   channel_out,
    output logic [rha_pkg::AVG_W-1:0]  rx_average,
    output logic [rha_pkg::AVG_W-1:0]  tx_average,
    output logic [rha_pkg::PEAK_W-1:0] rx_peak,
    output logic [rha_pkg::PEAK_W-1:0] tx_peak
);
    import rha_pkg::*;

    localparam int PW    = $clog2(HISTORY);
    localparam int CHW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int IW    = $clog2(HISTORY + 1);
    localparam int SUM_W = RATE_W + IW;
    localparam int NUM_W = SUM_W + BYTE_SHIFT + FRAC_BITS;
    localparam int DEN_W = IW + UNIT_W;
    localparam int DEPTH = 1 << (CHW + PW);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_WRITE = 5'b00010,
        ST_WALK  = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    typedef enum logic [1:0] {
        SEL_RX_AVG  = 2'd0,
        SEL_TX_AVG  = 2'd1,
        SEL_RX_PEAK = 2'd2,
        SEL_TX_PEAK = 2'd3
    } div_sel_t;

    state_t state_reg, state_next;

    // per-channel ring position of the newest sample and fill count
    logic [PW-1:0] head_reg [CHANNELS];
    logic [IW-1:0] cnt_reg  [CHANNELS];

    logic [2*RATE_W-1:0] mem [DEPTH];
    logic [2*RATE_W-1:0] mem_q;

    logic [CH_W-1:0]   ch_reg;
    logic [RATE_W-1:0] rx_reg, tx_reg;
    logic [IW-1:0]     win_reg, fill_reg;
    logic [UNIT_W-1:0] unit_reg;
    logic [DEN_W-1:0]  den_avg_reg;
    logic [PW-1:0]     wptr;
    logic [PW-1:0]     rd_ptr_reg;
    logic [IW-1:0]     rd_idx_reg, tag_reg;
    logic              rdv_reg;
    logic [SUM_W-1:0]  rx_sum_reg, tx_sum_reg;
    logic [RATE_W-1:0] rx_max_reg, tx_max_reg;
    div_sel_t          sel_reg;
    logic              div_go_reg;

    logic [AVG_W-1:0]  rx_avg_reg, tx_avg_reg;
    logic [PEAK_W-1:0] rx_pk_reg, tx_pk_reg;
    logic              out_valid_reg;
    logic [CH_W-1:0]   out_ch_reg;
    logic [AVG_W-1:0]  out_rx_avg_reg, out_tx_avg_reg;
    logic [PEAK_W-1:0] out_rx_pk_reg, out_tx_pk_reg;

    logic [CHW-1:0]    ch_idx;
    logic              div_start, div_done;
    logic [NUM_W-1:0]  div_num, div_quo;
    logic [DEN_W-1:0]  div_den;
    logic              walk_end, out_load;
    logic [RATE_W-1:0] rx_val, tx_val;
    logic              tag_live;

    assign ch_idx    = CHW'(ch_reg);
    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    assign wptr      = (head_reg[ch_idx] == PW'(HISTORY - 1)) ? '0
                                                               : head_reg[ch_idx] + 1'b1;
    assign walk_end  = (rd_idx_reg == IW'(HISTORY)) && !rdv_reg;
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);
    assign div_start = (state_reg == ST_DIV) && div_go_reg;
    assign tag_live  = (tag_reg < fill_reg);
    assign rx_val    = tag_live ? mem_q[2*RATE_W-1:RATE_W] : '0;
    assign tx_val    = tag_live ? mem_q[RATE_W-1:0] : '0;

    always_comb
    begin
        unique case (sel_reg)
            SEL_RX_AVG:  div_num = {rx_sum_reg, (BYTE_SHIFT + FRAC_BITS)'(0)};
            SEL_TX_AVG:  div_num = {tx_sum_reg, (BYTE_SHIFT + FRAC_BITS)'(0)};
            SEL_RX_PEAK: div_num = NUM_W'({rx_max_reg, BYTE_SHIFT'(0)});
            SEL_TX_PEAK: div_num = NUM_W'({tx_max_reg, BYTE_SHIFT'(0)});
            default:     div_num = '0;
        endcase
        div_den = (sel_reg == SEL_RX_AVG || sel_reg == SEL_TX_AVG) ? den_avg_reg
                                                                   : DEN_W'(unit_reg);
    end

    rha_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (q_valid) state_next = q_item.in_range ? ST_WRITE : ST_DONE;
            ST_WRITE: state_next = ST_WALK;
            ST_WALK:  if (walk_end) state_next = ST_DIV;
            ST_DIV:   if (div_done && sel_reg == SEL_TX_PEAK) state_next = ST_DONE;
            ST_DONE:  if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            rdv_reg       <= 1'b0;
            div_go_reg    <= 1'b0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                head_reg[c] <= '0;
                cnt_reg[c]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (state_reg == ST_WRITE)
            begin
                head_reg[ch_idx] <= wptr;
                if (cnt_reg[ch_idx] != IW'(HISTORY))
                    cnt_reg[ch_idx] <= cnt_reg[ch_idx] + 1'b1;
            end
            rdv_reg <= (state_reg == ST_WALK) && (rd_idx_reg != IW'(HISTORY));
            if (state_reg == ST_WALK && walk_end)
                div_go_reg <= 1'b1;
            else if (div_start)
                div_go_reg <= 1'b0;
            else if (state_reg == ST_DIV && div_done && sel_reg != SEL_TX_PEAK)
                div_go_reg <= 1'b1;
        end
    end

    // history memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WRITE)
            mem[{ch_idx, wptr}] <= {rx_reg, tx_reg};
        mem_q <= mem[{ch_idx, rd_ptr_reg}];
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            ch_reg   <= q_item.channel;
            rx_reg   <= q_item.rx;
            tx_reg   <= q_item.tx;
            unit_reg <= (unit_cfg == '0) ? UNIT_W'(1) : unit_cfg;
            if (win_cfg == '0)
                win_reg <= IW'(1);
            else if (32'(win_cfg) > HISTORY)
                win_reg <= IW'(HISTORY);
            else
                win_reg <= IW'(win_cfg);
            rx_avg_reg <= '0;
            tx_avg_reg <= '0;
            rx_pk_reg  <= '0;
            tx_pk_reg  <= '0;
        end
        if (state_reg == ST_WRITE)
        begin
            den_avg_reg <= DEN_W'(win_reg) * DEN_W'(unit_reg);
            fill_reg    <= (cnt_reg[ch_idx] != IW'(HISTORY)) ? cnt_reg[ch_idx] + 1'b1
                                                             : cnt_reg[ch_idx];
            rd_ptr_reg  <= wptr;
            rd_idx_reg  <= '0;
            rx_sum_reg  <= '0;
            tx_sum_reg  <= '0;
            rx_max_reg  <= '0;
            tx_max_reg  <= '0;
            sel_reg     <= SEL_RX_AVG;
        end
        if (state_reg == ST_WALK && rd_idx_reg != IW'(HISTORY))
        begin
            tag_reg    <= rd_idx_reg;
            rd_idx_reg <= rd_idx_reg + 1'b1;
            rd_ptr_reg <= (rd_ptr_reg == '0) ? PW'(HISTORY - 1) : rd_ptr_reg - 1'b1;
        end
        if (rdv_reg)
        begin
            if (tag_reg < win_reg)
            begin
                rx_sum_reg <= rx_sum_reg + SUM_W'(rx_val);
                tx_sum_reg <= tx_sum_reg + SUM_W'(tx_val);
            end
            if (rx_val > rx_max_reg)
                rx_max_reg <= rx_val;
            if (tx_val > tx_max_reg)
                tx_max_reg <= tx_val;
        end
        if (state_reg == ST_DIV && div_done)
        begin
            unique case (sel_reg)
                SEL_RX_AVG:  rx_avg_reg <= div_quo[AVG_W-1:0];
                SEL_TX_AVG:  tx_avg_reg <= div_quo[AVG_W-1:0];
                SEL_RX_PEAK: rx_pk_reg  <= div_quo[PEAK_W-1:0];
                SEL_TX_PEAK: tx_pk_reg  <= div_quo[PEAK_W-1:0];
                default:     rx_avg_reg <= rx_avg_reg;
            endcase
            sel_reg <= div_sel_t'(sel_reg + 2'd1);
        end
        if (out_load)
        begin
            out_ch_reg     <= ch_reg;
            out_rx_avg_reg <= rx_avg_reg;
            out_tx_avg_reg <= tx_avg_reg;
            out_rx_pk_reg  <= rx_pk_reg;
            out_tx_pk_reg  <= tx_pk_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign channel_out = out_ch_reg;
    assign rx_average  = out_rx_avg_reg;
    assign tx_average  = out_tx_avg_reg;
    assign rx_peak     = out_rx_pk_reg;
    assign tx_peak     = out_tx_pk_reg;

`ifndef SYNTH
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (rd_idx_reg <= IW'(HISTORY)))
        else $error("history walk ran past the depth");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result loaded outside the done state");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (state_reg == ST_WRITE || state_reg == ST_DONE))
        else $error("queue popped while busy");
`endif

endmodule

// ===== rtl/per_channel_rate_history_averager.sv =====
// Per-channel rate history averager with peak hold.
// Input channel (in_valid/in_stall): one transfer carries a channel number
// and a pair of byte-per-second readings, pushed into that channel's history
// if below CHANNELS (else all results are zero); one result transfer follows
// on the output channel (out_valid/out_stall) with the window average (8
// fraction bits) and the history peak for both directions, in bits per unit.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 sets the
// averaging window, index 1 the unit divisor. Write only while idle.
// The divider is NUM_W bits wide (51 at default sizes). The history walk
// through the memory's one read port and the bit-serial divider, run four
// times, make up the work per item; items are worked one at a time.
// A two-entry input queue takes items while the back end is busy.
// Reset clears all histories at once through per-channel fill counts,
// restores window 10 and divisor 1000; no clearing pass is needed.
// When the receiver stalls, the result holds in the output register; the back
// end may take the next queued item and waits before loading its own result.
module per_channel_rate_history_averager #(
    parameter int HISTORY  = rha_pkg::DEF_HISTORY,
    parameter int CHANNELS = rha_pkg::DEF_CHANNELS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [rha_pkg::CH_W-1:0]      channel,
    input  logic [rha_pkg::RATE_W-1:0]    rx_bytes_per_sec,
    input  logic [rha_pkg::RATE_W-1:0]    tx_bytes_per_sec,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [rha_pkg::CH_W-1:0]      channel_out,
    output logic [rha_pkg::AVG_W-1:0]     rx_average,
    output logic [rha_pkg::AVG_W-1:0]     tx_average,
    output logic [rha_pkg::PEAK_W-1:0]    rx_peak,
    output logic [rha_pkg::PEAK_W-1:0]    tx_peak,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rha_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rha_pkg::UNIT_W-1:0]    cfg_data
);
    import rha_pkg::*;

    logic [WIN_W-1:0]  win_reg;
    logic [UNIT_W-1:0] unit_reg;
    logic              q_valid, q_pop;
    rha_item_t         q_item;

    // config writes complete every cycle; unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg  <= WIN_RESET;
            unit_reg <= UNIT_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_WINDOW)
                win_reg <= cfg_data[WIN_W-1:0];
            else if (cfg_index == CFG_UNIT)
                unit_reg <= cfg_data;
        end
    end

    // front: accept, classify and queue items
    rha_front #(.CHANNELS(CHANNELS)) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .channel          (channel),
        .rx_bytes_per_sec (rx_bytes_per_sec),
        .tx_bytes_per_sec (tx_bytes_per_sec),
        .q_valid          (q_valid),
        .q_pop            (q_pop),
        .q_item           (q_item)
    );

    // back: update history, walk it, divide, hold the result
    rha_back #(.HISTORY(HISTORY), .CHANNELS(CHANNELS)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_item      (q_item),
        .win_cfg     (win_reg),
        .unit_cfg    (unit_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .channel_out (channel_out),
        .rx_average  (rx_average),
        .tx_average  (tx_average),
        .rx_peak     (rx_peak),
        .tx_peak     (tx_peak)
    );

endmodule

// ===== verif/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rha_pkg::*;

    localparam int HIST      = DEF_HISTORY;
    localparam int CHANS     = DEF_CHANNELS;
    localparam int CYCLE_CAP = 3000000;
    // Settling time after the last result, with a margin.
    localparam int DRAIN     = 500;

    typedef struct {
        logic [CH_W-1:0]   ch;
        logic [RATE_W-1:0] rx;
        logic [RATE_W-1:0] tx;
    } rate_item_t;

    typedef struct {
        logic [CH_W-1:0]   ch;
        logic [AVG_W-1:0]  rx_avg;
        logic [AVG_W-1:0]  tx_avg;
        logic [PEAK_W-1:0] rx_pk;
        logic [PEAK_W-1:0] tx_pk;
    } rate_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [CH_W-1:0]      channel = '0;
    logic [RATE_W-1:0]    rx_bytes_per_sec = '0;
    logic [RATE_W-1:0]    tx_bytes_per_sec = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [CH_W-1:0]      channel_out;
    logic [AVG_W-1:0]     rx_average;
    logic [AVG_W-1:0]     tx_average;
    logic [PEAK_W-1:0]    rx_peak;
    logic [PEAK_W-1:0]    tx_peak;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [UNIT_W-1:0]    cfg_data = '0;

    // Shadow copy of the per-channel histories and the two registers.
    logic [RATE_W-1:0] rx_hist [CHANS][HIST];
    logic [RATE_W-1:0] tx_hist [CHANS][HIST];
    logic [WIN_W-1:0]  window_reg = WIN_RESET;
    logic [UNIT_W-1:0] unit_reg = UNIT_RESET;

    rate_item_t   pending_items[$];
    rate_result_t results_due[$];

    int  errors = 0;
    int  cycles = 0;
    bit  calm = 1'b0;       // set in the last part of the run: no idling, no receiver stalls
    int  idle_odds = 10;    // one chance in this many to start an idle burst
    bit  in_took = 1'b0;
    int  in_gap = 0;
    int  out_gap = 0;

    per_channel_rate_history_averager DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .channel          (channel),
        .rx_bytes_per_sec (rx_bytes_per_sec),
        .tx_bytes_per_sec (tx_bytes_per_sec),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .channel_out      (channel_out),
        .rx_average       (rx_average),
        .tx_average       (tx_average),
        .rx_peak          (rx_peak),
        .tx_peak          (tx_peak),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #10 clk = ~clk;

    // Mean of the newest samples in units with 8 fraction bits, truncated.
    function automatic logic [AVG_W-1:0] window_mean(input logic [RATE_W-1:0] h [HIST],
                                                     input int win, input longint unsigned unit);
        longint unsigned total;
        total = 0;
        for (int i = 0; i < win; i++)
            total += h[i];
        return AVG_W'(((total << BYTE_SHIFT) << FRAC_BITS) / (longint'(win) * unit));
    endfunction

    function automatic logic [PEAK_W-1:0] history_max(input logic [RATE_W-1:0] h [HIST],
                                                      input longint unsigned unit);
        longint unsigned top;
        top = 0;
        for (int i = 0; i < HIST; i++)
            if (h[i] > top)
                top = h[i];
        return PEAK_W'((top << BYTE_SHIFT) / unit);
    endfunction

    // Push one reading pair into its channel history and queue the result it yields.
    function automatic void push_and_predict(input rate_item_t it);
        rate_result_t r;
        int win;
        longint unsigned unit;
        r = '{ch: it.ch, rx_avg: '0, tx_avg: '0, rx_pk: '0, tx_pk: '0};
        if (it.ch < CHANS) begin
            win  = (window_reg == 0) ? 1 : ((window_reg > HIST) ? HIST : int'(window_reg));
            unit = (unit_reg == 0) ? 1 : longint'(unit_reg);
            for (int i = HIST - 1; i > 0; i--) begin
                rx_hist[it.ch][i] = rx_hist[it.ch][i-1];
                tx_hist[it.ch][i] = tx_hist[it.ch][i-1];
            end
            rx_hist[it.ch][0] = it.rx;
            tx_hist[it.ch][0] = it.tx;
            r.rx_avg = window_mean(rx_hist[it.ch], win, unit);
            r.tx_avg = window_mean(tx_hist[it.ch], win, unit);
            r.rx_pk  = history_max(rx_hist[it.ch], unit);
            r.tx_pk  = history_max(tx_hist[it.ch], unit);
        end
        results_due.push_back(r);
    endfunction

    // Input side: predict on each accepted transfer.
    always @(posedge clk) begin
        in_took <= in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
            push_and_predict('{ch: channel, rx: rx_bytes_per_sec, tx: tx_bytes_per_sec});
    end

    // Driver: hold a stalled payload, otherwise idle in bursts or advance the queue.
    always @(negedge clk) begin : drive_in
        rate_item_t nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (in_valid && !in_took) begin
            // hold the payload until it is taken
        end else if (in_gap > 0) begin
            in_gap   <= in_gap - 1;
            in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, idle_odds - 1) == 0) begin
            in_gap   <= $urandom_range(0, 5);
            in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
            nxt = pending_items.pop_front();
            in_valid         <= 1'b1;
            channel          <= nxt.ch;
            rx_bytes_per_sec <= nxt.rx;
            tx_bytes_per_sec <= nxt.tx;
        end else begin
            in_valid <= 1'b0;
        end
    end

    // Receiver stall: random bursts, none once calm.
    always @(negedge clk) begin
        if (!rst_n || calm) begin
            out_stall <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap   <= out_gap - 1;
            out_stall <= 1'b1;
        end else if ($urandom_range(0, idle_odds - 1) == 0) begin
            out_gap   <= $urandom_range(0, 5);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Monitor: compare each result transfer with the oldest prediction.
    always @(posedge clk) begin : check_out
        rate_result_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (results_due.size() == 0) begin
                $display("%0t: unexpected result, channel_out=%0d", $time, channel_out);
                errors++;
            end else begin
                want = results_due.pop_front();
                if (channel_out !== want.ch) begin
                    $display("%0t: channel_out expected %0d actual %0d",
                             $time, want.ch, channel_out);
                    errors++;
                end
                if (rx_average !== want.rx_avg) begin
                    $display("%0t: rx_average expected %0d actual %0d",
                             $time, want.rx_avg, rx_average);
                    errors++;
                end
                if (tx_average !== want.tx_avg) begin
                    $display("%0t: tx_average expected %0d actual %0d",
                             $time, want.tx_avg, tx_average);
                    errors++;
                end
                if (rx_peak !== want.rx_pk) begin
                    $display("%0t: rx_peak expected %0d actual %0d",
                             $time, want.rx_pk, rx_peak);
                    errors++;
                end
                if (tx_peak !== want.tx_pk) begin
                    $display("%0t: tx_peak expected %0d actual %0d",
                             $time, want.tx_pk, tx_peak);
                    errors++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Half full-range random readings, with zero, full scale and narrow values mixed in.
    function automatic logic [RATE_W-1:0] pick_rate();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return RATE_W'($urandom_range(0, 2000));
            4:       return RATE_W'($urandom_range(0, 1 << 20));
            default: return RATE_W'($urandom());
        endcase
    endfunction

    task automatic queue_item(input int ch, input logic [RATE_W-1:0] rx,
                              input logic [RATE_W-1:0] tx);
        pending_items.push_back('{ch: CH_W'(ch), rx: rx, tx: tx});
    endtask

    task automatic queue_random(input int n);
        for (int i = 0; i < n; i++)
            queue_item($urandom_range(0, (1 << CH_W) - 1), pick_rate(), pick_rate());
    endtask

    // Wait until every transfer is out and the back end has settled.
    task automatic wait_idle();
        while (pending_items.size() != 0 || in_valid || results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [UNIT_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_WINDOW)
            window_reg = val[WIN_W-1:0];
        else if (idx == CFG_UNIT)
            unit_reg = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        for (int c = 0; c < CHANS; c++)
            for (int i = 0; i < HIST; i++) begin
                rx_hist[c][i] = '0;
                tx_hist[c][i] = '0;
            end
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset settings, empty histories, extremes, every channel.
        queue_item(0, '0, '0);
        queue_item(7, '1, '1);
        queue_item(7, '1, '0);
        queue_item(7, '0, '1);
        queue_item(3, 32'h8000_0000, 32'h0000_0001);
        queue_item(3, 32'h5555_5555, 32'hAAAA_AAAA);
        for (int c = 0; c < CHANS; c++)
            queue_item(c, RATE_W'(1000 * (c + 1)), RATE_W'(125 * c));
        wait_idle();

        // Window 1 and unit 1: average is the newest sample, in bits with 8 fraction bits.
        write_reg(CFG_WINDOW, 20'd1);
        write_reg(CFG_UNIT, 20'd1);
        queue_item(7, '1, '1);
        queue_item(2, 32'd3, 32'd0);
        queue_random(140);
        wait_idle();

        // Zero window and zero unit are both taken as one.
        write_reg(CFG_WINDOW, 20'd0);
        write_reg(CFG_UNIT, 20'd0);
        queue_item(5, '1, 32'd7);
        queue_random(120);
        wait_idle();

        // Full depth window, unit 1000000; upper data bits ignored for the window.
        write_reg(CFG_WINDOW, 20'hFA580);
        write_reg(CFG_UNIT, 20'd1000000);
        queue_random(160);
        wait_idle();

        // Window beyond depth is clamped; a spare index changes nothing.
        write_reg(CFG_WINDOW, 20'd255);
        write_reg(CFG_UNIT, 20'hFFFFF);
        write_reg(2'd3, 20'd5);
        queue_random(140);
        wait_idle();

        // Random mid settings, heavier idling.
        idle_odds = 3;
        write_reg(CFG_WINDOW, 20'($urandom_range(2, 127)));
        write_reg(CFG_UNIT, 20'($urandom_range(2, 999999)));
        queue_random(140);
        wait_idle();

        // Last part: back to reset-like settings with no idling.
        calm = 1'b1;
        write_reg(CFG_WINDOW, 20'(WIN_RESET));
        write_reg(CFG_UNIT, 20'(UNIT_RESET));
        queue_random(140);
        wait_idle();

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
